[rtl/rpks_pkg.sv]
// Shared types and constants of the render packet key sorter.
`timescale 1ns / 1ps
package rpks_pkg;

  localparam int unsigned HandleW = 16;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned ModeW   = 2;

  localparam logic [ModeW-1:0] ModeNone     = 2'd0;
  localparam logic [ModeW-1:0] ModeMaterial = 2'd1;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } rpks_state_e;

  typedef struct packed {
    logic [HandleW-1:0] pipeline_handle;
    logic [HandleW-1:0] tex_handle;
    logic [HandleW-1:0] vertex_handle;
    logic [HandleW-1:0] index_handle;
    logic               end_of_batch;
  } rpks_in_t;

  typedef struct packed {
    logic [HandleW-1:0] out_pipeline;
    logic [HandleW-1:0] out_texture;
    logic [HandleW-1:0] out_vertex;
    logic [HandleW-1:0] out_index;
    logic [SlotW-1:0]   load_slot;
    logic               overflow;
    logic               final_result;
  } rpks_out_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic drain;
    logic sort_en;
  } rpks_ctrl_t;

endpackage

[rtl/render_packet_key_sorter.sv]
// Top level of the render packet key sorter: control, cell chain and result register.
//
// Packets are loaded one per beat: a packet is taken at a rising edge with start_i high
// and busy_o low, and is inserted into its sorted place in a chain of MAX_PACKETS cells
// in that same cycle, so loading runs at one packet per cycle while busy_o is low.
// Packets beyond the chain capacity are dropped and flag the batch as overflowed.
// A packet with end_of_batch set closes the batch. busy_o then stays high while the
// chain drains its N stored packets, shifting toward its head one cell per cycle. The
// first result beat reaches the ports after the state register has entered drain and the
// head cell has passed through the result register; the N results follow on consecutive
// cycles, the last one marked final_result.
// Results are strobed by result_valid_o for one cycle each; the receiver cannot stall.
// The ordering mode is to be written through mode_we_i/mode_i only while idle; the
// block itself does not enforce it. Mode zero keeps load order, any other mode sorts by
// pipeline, texture, vertex and index handles. Reset empties the chain, clears the
// packet count and overflow flag, and sets the mode to material sort.
`timescale 1ns / 1ps
module render_packet_key_sorter
  import rpks_pkg::*;
#(
  parameter int unsigned MAX_PACKETS = 64,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  rpks_in_t         packet_i,
  input  logic             mode_we_i,
  input  logic [ModeW-1:0] mode_i,
  output logic             result_valid_o,
  output rpks_out_t        result_o
);

  localparam int unsigned KeyW = 4 * HANDLE_BITS;
  localparam int unsigned CntW = $clog2(MAX_PACKETS + 1);

  rpks_state_e      state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [ModeW-1:0] mode_q;
  logic             out_valid_q, out_valid_d;
  rpks_out_t        out_q, out_d;

  logic             accept;
  logic             room;
  rpks_ctrl_t       ctrl;
  logic [KeyW-1:0]  new_key;
  logic [SlotW-1:0] new_slot;

  logic             cell_ins   [MAX_PACKETS];
  logic             cell_valid [MAX_PACKETS];
  logic [KeyW-1:0]  cell_key   [MAX_PACKETS];
  logic [SlotW-1:0] cell_slot  [MAX_PACKETS];

  assign busy_o   = (state_q == ST_DRAIN);
  assign accept   = start_i && !busy_o;
  assign room     = count_q < CntW'(MAX_PACKETS);
  assign new_key  = {packet_i.pipeline_handle[HANDLE_BITS-1:0],
                     packet_i.tex_handle[HANDLE_BITS-1:0],
                     packet_i.vertex_handle[HANDLE_BITS-1:0],
                     packet_i.index_handle[HANDLE_BITS-1:0]};
  assign new_slot = SlotW'(count_q);

  assign ctrl.insert  = accept && room;
  assign ctrl.drain   = (state_q == ST_DRAIN);
  assign ctrl.sort_en = (mode_q != ModeNone);

  for (genvar i = 0; i < MAX_PACKETS; i++) begin : g_cell
    logic             l_ins, l_valid, r_valid;
    logic [KeyW-1:0]  l_key, r_key;
    logic [SlotW-1:0] l_slot, r_slot;

    if (i == 0) begin : g_head
      assign l_ins   = 1'b0;
      assign l_valid = 1'b0;
      assign l_key   = '0;
      assign l_slot  = '0;
    end else begin : g_mid
      assign l_ins   = cell_ins[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_key   = cell_key[i-1];
      assign l_slot  = cell_slot[i-1];
    end

    if (i == MAX_PACKETS - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_slot  = '0;
    end else begin : g_body
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
      assign r_slot  = cell_slot[i+1];
    end

    rpks_cell #(
      .KeyW(KeyW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_key_i    (new_key),
      .new_slot_i   (new_slot),
      .left_ins_i   (l_ins),
      .left_valid_i (l_valid),
      .left_key_i   (l_key),
      .left_slot_i  (l_slot),
      .right_valid_i(r_valid),
      .right_key_i  (r_key),
      .right_slot_i (r_slot),
      .ins_o        (cell_ins[i]),
      .valid_o      (cell_valid[i]),
      .key_o        (cell_key[i]),
      .slot_o       (cell_slot[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (packet_i.end_of_batch) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // The head cell is emitted each cycle while the chain shifts forward.
        out_valid_d        = 1'b1;
        out_d.out_pipeline = HandleW'(cell_key[0][4*HANDLE_BITS-1:3*HANDLE_BITS]);
        out_d.out_texture  = HandleW'(cell_key[0][3*HANDLE_BITS-1:2*HANDLE_BITS]);
        out_d.out_vertex   = HandleW'(cell_key[0][2*HANDLE_BITS-1:HANDLE_BITS]);
        out_d.out_index    = HandleW'(cell_key[0][HANDLE_BITS-1:0]);
        out_d.load_slot    = cell_slot[0];
        out_d.overflow     = ovf_q;
        out_d.final_result = !cell_valid[1];
        if (!cell_valid[1]) begin
          state_d = ST_LOAD;
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      mode_q      <= ModeMaterial;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (mode_we_i) begin
        mode_q <= mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  a_strobe_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_DRAIN))
    else $error("result strobe without a drain cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_PACKETS))
    else $error("packet count beyond chain capacity");

  a_head_valid_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> cell_valid[0])
    else $error("draining an empty chain head");

  a_gap_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.final_result) |=> !result_valid_o)
    else $error("result beat directly after the final one");

endmodule

[rtl/rpks_cell.sv]
// One cell of the insertion chain: holds one packet key and its load slot.
`timescale 1ns / 1ps
module rpks_cell
  import rpks_pkg::*;
#(
  parameter int unsigned KeyW = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpks_ctrl_t       ctrl_i,
  input  logic [KeyW-1:0]  new_key_i,
  input  logic [SlotW-1:0] new_slot_i,
  input  logic             left_ins_i,
  input  logic             left_valid_i,
  input  logic [KeyW-1:0]  left_key_i,
  input  logic [SlotW-1:0] left_slot_i,
  input  logic             right_valid_i,
  input  logic [KeyW-1:0]  right_key_i,
  input  logic [SlotW-1:0] right_slot_i,
  output logic             ins_o,
  output logic             valid_o,
  output logic [KeyW-1:0]  key_o,
  output logic [SlotW-1:0] slot_o
);

  logic             valid_q, valid_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             greater;

  // A strictly greater key yields its place, so equal keys keep load order.
  assign greater = valid_q && ctrl_i.sort_en && (key_q > new_key_i);
  assign ins_o   = greater || !valid_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    slot_d  = slot_q;
    if (ctrl_i.drain) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      slot_d  = right_slot_i;
    end else if (ctrl_i.insert && ins_o) begin
      if (left_ins_i) begin
        valid_d = left_valid_i;
        key_d   = left_key_i;
        slot_d  = left_slot_i;
      end else begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        slot_d  = new_slot_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    slot_q <= slot_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign slot_o  = slot_q;

endmodule
